[hw/rtl/dpa_pkg.sv]
// ----------------------------------------------------------------------------
// dpa_pkg: shared types and constants of the dual pool node id allocator
// Request and result codes, the queued operation word and the result word.
// ----------------------------------------------------------------------------
package dpa_pkg;

    // default pool geometry and depth limit
    localparam int unsigned CELL_POOL_SIZE_DEF = 1024;
    localparam int unsigned LEAF_POOL_SIZE_DEF = 1024;
    localparam int unsigned DEPTH_LIMIT_DEF    = 10;

    // field widths
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned REF_W   = 32;
    localparam int unsigned DEPTH_W = 4;
    localparam int unsigned SLOT_W  = REF_W - 1;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned IN_W    = 40;
    localparam int unsigned OUT_W   = 40;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC_CELL = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC_LEAF = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE       = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP     = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DEPTH_BAD = 2'd3;

    localparam logic [REF_W-1:0] BAD_REF  = '1;
    localparam logic [REF_W-1:0] LEAF_BIT = 32'h8000_0000;

    // decoded operation kind
    typedef enum logic [2:0] {
        OP_ALLOC  = 3'd0,
        OP_FREE   = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_LOOKUP = 3'd3,
        OP_NOP    = 3'd4
    } op_kind_t;

    // classified request handed from front to back
    typedef struct packed {
        op_kind_t            kind;
        logic                leaf;
        logic                ref_bad;
        logic                depth_bad;
        logic [SLOT_W-1:0]   slot;
        logic [DEPTH_W-1:0]  depth;
    } op_t;

    // result word, packed in output order from the top bit down
    typedef struct packed {
        logic [DEPTH_W-1:0]  found_depth;
        logic                is_leaf_node;
        logic                found;
        logic [STAT_W-1:0]   status;
        logic [REF_W-1:0]    alloc_ref;
    } res_t;

endpackage

[hw/rtl/dual_pool_node_id_allocator_core.sv]
// ----------------------------------------------------------------------------
// dual_pool_node_id_allocator_core: node identifier allocator, two pools
// Hands out, frees and looks up cell and leaf identifiers.
// ----------------------------------------------------------------------------
// usage:
//   request channel s_*: tuser carries the request code (alloc cell, alloc
//   leaf, free, clear, lookup), tdata the identifier and the node depth.
//   result channel m_*: one result transaction per request, in request order,
//   with the allocated identifier, status, found flag, leaf flag and depth.
//   a request enters a two-entry queue at the transaction; the execution side
//   pops it in its execute state and registers the result for the output state,
//   passing first through a pop or lookup state for an allocation that reuses
//   a freed slot and for an in-range lookup, which wait on a registered memory read.
//   the execution state machine takes no new request until the result has been
//   accepted, so requests are carried out one at a time.
//   reset empties both pools and the queue; memories need no clearing since
//   only entries below a stack top or a used count are ever read.
//   when the receiver stalls the result is held and the queue keeps taking
//   requests until both entries are occupied, then s_tready drops.
// ----------------------------------------------------------------------------
module dual_pool_node_id_allocator_core #(
    parameter int unsigned CELL_POOL_SIZE = dpa_pkg::CELL_POOL_SIZE_DEF,
    parameter int unsigned LEAF_POOL_SIZE = dpa_pkg::LEAF_POOL_SIZE_DEF,
    parameter int unsigned DEPTH_LIMIT    = dpa_pkg::DEPTH_LIMIT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [dpa_pkg::IN_W-1:0]   s_tdata,   // node_ref[31:0], node_depth[35:32], zero pad
    input  logic [dpa_pkg::FUNC_W-1:0] s_tuser,   // func[2:0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [dpa_pkg::OUT_W-1:0]  m_tdata    // alloc_ref[31:0], status[33:32], found[34],
                                                  // is_leaf_node[35], found_depth[39:36]
);

    logic         q_push, q_pop, q_full, q_valid;
    dpa_pkg::op_t q_in, q_out;

    // intake and classification
    dpa_front #(
        .DEPTH_LIMIT (DEPTH_LIMIT)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    // request queue
    dpa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    // execution and pool state
    dpa_back #(
        .CELL_POOL_SIZE (CELL_POOL_SIZE),
        .LEAF_POOL_SIZE (LEAF_POOL_SIZE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[hw/rtl/dpa_front.sv]
// ----------------------------------------------------------------------------
// dpa_front: request intake and classification
// Accepts request transactions, decodes the request code and splits the
// identifier into pool and slot before the request enters the queue.
// ----------------------------------------------------------------------------
module dpa_front #(
    parameter int unsigned DEPTH_LIMIT = dpa_pkg::DEPTH_LIMIT_DEF
) (
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [dpa_pkg::IN_W-1:0]   s_tdata,   // node_ref[31:0], node_depth[35:32]
    input  logic [dpa_pkg::FUNC_W-1:0] s_tuser,   // func[2:0]
    input  logic                       q_full,
    output logic                       q_push,
    output dpa_pkg::op_t               q_data
);

    logic [dpa_pkg::REF_W-1:0]   node_ref;
    logic [dpa_pkg::DEPTH_W-1:0] node_depth;

    assign node_ref   = s_tdata[dpa_pkg::REF_W-1:0];
    assign node_depth = s_tdata[dpa_pkg::REF_W +: dpa_pkg::DEPTH_W];

    // intake handshake
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    // classify the request
    always_comb
    begin
        q_data.kind      = dpa_pkg::OP_NOP;
        q_data.leaf      = node_ref[dpa_pkg::REF_W-1];
        q_data.ref_bad   = (node_ref == dpa_pkg::BAD_REF);
        q_data.depth_bad = (node_depth > dpa_pkg::DEPTH_W'(DEPTH_LIMIT));
        q_data.slot      = node_ref[dpa_pkg::SLOT_W-1:0];
        q_data.depth     = node_depth;
        unique case (s_tuser)
            dpa_pkg::FUNC_ALLOC_CELL:
            begin
                q_data.kind = dpa_pkg::OP_ALLOC;
                q_data.leaf = 1'b0;
            end
            dpa_pkg::FUNC_ALLOC_LEAF:
            begin
                q_data.kind = dpa_pkg::OP_ALLOC;
                q_data.leaf = 1'b1;
            end
            dpa_pkg::FUNC_FREE:   q_data.kind = dpa_pkg::OP_FREE;
            dpa_pkg::FUNC_CLEAR:  q_data.kind = dpa_pkg::OP_CLEAR;
            dpa_pkg::FUNC_LOOKUP: q_data.kind = dpa_pkg::OP_LOOKUP;
            default:              q_data.kind = dpa_pkg::OP_NOP;
        endcase
    end

endmodule

[hw/rtl/dpa_queue.sv]
// ----------------------------------------------------------------------------
// dpa_queue: two-entry request queue
// Decouples the intake side from the execution side.
// ----------------------------------------------------------------------------
module dpa_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  dpa_pkg::op_t push_data,
    input  logic         pop,
    output logic         full,
    output logic         valid,
    output dpa_pkg::op_t pop_data
);

    localparam logic [1:0] QDEPTH = 2'd2;

    dpa_pkg::op_t entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full     = (count_reg == QDEPTH);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QDEPTH) else $error("queue fill count beyond depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid) else $error("queue read while empty");
`endif

endmodule

[hw/rtl/dpa_back.sv]
// ----------------------------------------------------------------------------
// dpa_back: pool state and request execution
// Holds both pools' counters, free stacks and depth memories, carries out
// one queued request at a time and holds its result for the output side.
// ----------------------------------------------------------------------------
module dpa_back #(
    parameter int unsigned CELL_POOL_SIZE = dpa_pkg::CELL_POOL_SIZE_DEF,
    parameter int unsigned LEAF_POOL_SIZE = dpa_pkg::LEAF_POOL_SIZE_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  dpa_pkg::op_t              q_data,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [dpa_pkg::OUT_W-1:0] m_tdata
);

    localparam int unsigned CSW = $clog2(CELL_POOL_SIZE);
    localparam int unsigned LSW = $clog2(LEAF_POOL_SIZE);
    localparam int unsigned CUW = $clog2(CELL_POOL_SIZE + 1);
    localparam int unsigned LUW = $clog2(LEAF_POOL_SIZE + 1);
    localparam logic [CUW-1:0] CELL_MAX = CUW'(CELL_POOL_SIZE);
    localparam logic [LUW-1:0] LEAF_MAX = LUW'(LEAF_POOL_SIZE);

    typedef enum logic [3:0] {
        S_EXEC = 4'b0001,
        S_POP  = 4'b0010,
        S_LOOK = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    dpa_pkg::op_t  op_reg, op_next;
    dpa_pkg::res_t res_reg, res_next;
    logic [CUW-1:0] cell_used_reg, cell_used_next;
    logic [LUW-1:0] leaf_used_reg, leaf_used_next;
    logic [CUW-1:0] cell_top_reg, cell_top_next;
    logic [LUW-1:0] leaf_top_reg, leaf_top_next;

    // memories
    logic [CSW-1:0]              cell_stack [CELL_POOL_SIZE];
    logic [LSW-1:0]              leaf_stack [LEAF_POOL_SIZE];
    logic [dpa_pkg::DEPTH_W-1:0] cell_depths [CELL_POOL_SIZE];
    logic [dpa_pkg::DEPTH_W-1:0] leaf_depths [LEAF_POOL_SIZE];

    logic                        cstk_we, cstk_re, lstk_we, lstk_re;
    logic [CSW-1:0]              cstk_waddr, cstk_raddr, cstk_wdata, cstk_rdata_reg;
    logic [LSW-1:0]              lstk_waddr, lstk_raddr, lstk_wdata, lstk_rdata_reg;
    logic                        cdep_we, cdep_re, ldep_we, ldep_re;
    logic [CSW-1:0]              cdep_waddr, cdep_raddr;
    logic [LSW-1:0]              ldep_waddr, ldep_raddr;
    logic [dpa_pkg::DEPTH_W-1:0] dep_wdata, cdep_rdata_reg, ldep_rdata_reg;

    // derived values
    logic [CUW-1:0] cell_top_dec;
    logic [LUW-1:0] leaf_top_dec;
    logic           cell_slot_ok, leaf_slot_ok;
    logic [CSW-1:0] pop_cell_slot;
    logic [LSW-1:0] pop_leaf_slot;

    assign cell_top_dec  = cell_top_reg - 1'b1;
    assign leaf_top_dec  = leaf_top_reg - 1'b1;
    assign cell_slot_ok  = (q_data.slot < dpa_pkg::SLOT_W'(cell_used_reg));
    assign leaf_slot_ok  = (q_data.slot < dpa_pkg::SLOT_W'(leaf_used_reg));
    assign pop_cell_slot = cstk_rdata_reg;
    assign pop_leaf_slot = lstk_rdata_reg;

    // output side
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {res_reg.found_depth, res_reg.is_leaf_node, res_reg.found,
                       res_reg.status, res_reg.alloc_ref};

    // request execution
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        res_next       = res_reg;
        cell_used_next = cell_used_reg;
        leaf_used_next = leaf_used_reg;
        cell_top_next  = cell_top_reg;
        leaf_top_next  = leaf_top_reg;
        q_pop          = 1'b0;
        cstk_we        = 1'b0;
        cstk_re        = 1'b0;
        lstk_we        = 1'b0;
        lstk_re        = 1'b0;
        cdep_we        = 1'b0;
        cdep_re        = 1'b0;
        ldep_we        = 1'b0;
        ldep_re        = 1'b0;
        cstk_waddr     = cell_top_reg[CSW-1:0];
        cstk_raddr     = cell_top_dec[CSW-1:0];
        cstk_wdata     = q_data.slot[CSW-1:0];
        lstk_waddr     = leaf_top_reg[LSW-1:0];
        lstk_raddr     = leaf_top_dec[LSW-1:0];
        lstk_wdata     = q_data.slot[LSW-1:0];
        cdep_waddr     = cell_used_reg[CSW-1:0];
        cdep_raddr     = q_data.slot[CSW-1:0];
        ldep_waddr     = leaf_used_reg[LSW-1:0];
        ldep_raddr     = q_data.slot[LSW-1:0];
        dep_wdata      = q_data.depth;

        unique case (state_reg)
            S_EXEC:
            begin
                if (q_valid)
                begin
                    q_pop                 = 1'b1;
                    op_next               = q_data;
                    state_next            = S_OUT;
                    res_next.alloc_ref    = dpa_pkg::BAD_REF;
                    res_next.status       = dpa_pkg::STAT_OK;
                    res_next.found        = 1'b0;
                    res_next.is_leaf_node = 1'b0;
                    res_next.found_depth  = '0;
                    unique case (q_data.kind)
                        dpa_pkg::OP_ALLOC:
                        begin
                            if (q_data.depth_bad)
                            begin
                                res_next.status = dpa_pkg::STAT_DEPTH_BAD;
                            end
                            else if (!q_data.leaf)
                            begin
                                if (cell_top_reg != '0)
                                begin
                                    // reuse the most recently freed cell
                                    cell_top_next = cell_top_dec;
                                    cstk_re       = 1'b1;
                                    state_next    = S_POP;
                                end
                                else if (cell_used_reg < CELL_MAX)
                                begin
                                    cdep_we            = 1'b1;
                                    cell_used_next     = cell_used_reg + 1'b1;
                                    res_next.alloc_ref = dpa_pkg::REF_W'(cell_used_reg);
                                end
                                else
                                begin
                                    res_next.status = dpa_pkg::STAT_FULL;
                                end
                            end
                            else
                            begin
                                if (leaf_top_reg != '0)
                                begin
                                    // reuse the most recently freed leaf
                                    leaf_top_next = leaf_top_dec;
                                    lstk_re       = 1'b1;
                                    state_next    = S_POP;
                                end
                                else if (leaf_used_reg < LEAF_MAX)
                                begin
                                    ldep_we               = 1'b1;
                                    leaf_used_next        = leaf_used_reg + 1'b1;
                                    res_next.alloc_ref    = dpa_pkg::REF_W'(leaf_used_reg)
                                                            | dpa_pkg::LEAF_BIT;
                                    res_next.is_leaf_node = 1'b1;
                                end
                                else
                                begin
                                    res_next.status = dpa_pkg::STAT_FULL;
                                end
                            end
                        end
                        dpa_pkg::OP_FREE:
                        begin
                            if (!q_data.ref_bad)
                            begin
                                if (!q_data.leaf)
                                begin
                                    if (!cell_slot_ok)
                                    begin
                                        res_next.status = dpa_pkg::STAT_RANGE;
                                    end
                                    else if (cell_top_reg >= CELL_MAX)
                                    begin
                                        res_next.status = dpa_pkg::STAT_FULL;
                                    end
                                    else
                                    begin
                                        cstk_we       = 1'b1;
                                        cell_top_next = cell_top_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    if (!leaf_slot_ok)
                                    begin
                                        res_next.status = dpa_pkg::STAT_RANGE;
                                    end
                                    else if (leaf_top_reg >= LEAF_MAX)
                                    begin
                                        res_next.status = dpa_pkg::STAT_FULL;
                                    end
                                    else
                                    begin
                                        lstk_we       = 1'b1;
                                        leaf_top_next = leaf_top_reg + 1'b1;
                                    end
                                end
                            end
                        end
                        dpa_pkg::OP_CLEAR:
                        begin
                            cell_used_next = '0;
                            leaf_used_next = '0;
                            cell_top_next  = '0;
                            leaf_top_next  = '0;
                        end
                        dpa_pkg::OP_LOOKUP:
                        begin
                            if (!q_data.ref_bad)
                            begin
                                if (!q_data.leaf && cell_slot_ok)
                                begin
                                    cdep_re    = 1'b1;
                                    state_next = S_LOOK;
                                end
                                else if (q_data.leaf && leaf_slot_ok)
                                begin
                                    ldep_re    = 1'b1;
                                    state_next = S_LOOK;
                                end
                                else
                                begin
                                    res_next.status = dpa_pkg::STAT_RANGE;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POP:
            begin
                // slot from the free stack is now valid, record its depth
                dep_wdata  = op_reg.depth;
                state_next = S_OUT;
                if (!op_reg.leaf)
                begin
                    cdep_we            = 1'b1;
                    cdep_waddr         = pop_cell_slot;
                    res_next.alloc_ref = dpa_pkg::REF_W'(pop_cell_slot);
                end
                else
                begin
                    ldep_we               = 1'b1;
                    ldep_waddr            = pop_leaf_slot;
                    res_next.alloc_ref    = dpa_pkg::REF_W'(pop_leaf_slot) | dpa_pkg::LEAF_BIT;
                    res_next.is_leaf_node = 1'b1;
                end
            end
            S_LOOK:
            begin
                state_next            = S_OUT;
                res_next.found        = 1'b1;
                res_next.is_leaf_node = op_reg.leaf;
                res_next.found_depth  = op_reg.leaf ? ldep_rdata_reg : cdep_rdata_reg;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_EXEC;
                end
            end
            default: state_next = S_EXEC;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_EXEC;
            cell_used_reg <= '0;
            leaf_used_reg <= '0;
            cell_top_reg  <= '0;
            leaf_top_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cell_used_reg <= cell_used_next;
            leaf_used_reg <= leaf_used_next;
            cell_top_reg  <= cell_top_next;
            leaf_top_reg  <= leaf_top_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        res_reg <= res_next;
    end

    // free stacks
    always_ff @(posedge clk)
    begin
        if (cstk_we)
        begin
            cell_stack[cstk_waddr] <= cstk_wdata;
        end
        if (cstk_re)
        begin
            cstk_rdata_reg <= cell_stack[cstk_raddr];
        end
        if (lstk_we)
        begin
            leaf_stack[lstk_waddr] <= lstk_wdata;
        end
        if (lstk_re)
        begin
            lstk_rdata_reg <= leaf_stack[lstk_raddr];
        end
    end

    // depth memories
    always_ff @(posedge clk)
    begin
        if (cdep_we)
        begin
            cell_depths[cdep_waddr] <= dep_wdata;
        end
        if (cdep_re)
        begin
            cdep_rdata_reg <= cell_depths[cdep_raddr];
        end
        if (ldep_we)
        begin
            leaf_depths[ldep_waddr] <= dep_wdata;
        end
        if (ldep_re)
        begin
            ldep_rdata_reg <= leaf_depths[ldep_raddr];
        end
    end

`ifndef SYNTH
    a_cell_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cell_top_reg <= CELL_MAX && cell_used_reg <= CELL_MAX)
        else $error("cell pool counter beyond pool size");
    a_leaf_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        leaf_top_reg <= LEAF_MAX && leaf_used_reg <= LEAF_MAX)
        else $error("leaf pool counter beyond pool size");
    a_mem_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP || state_reg == S_LOOK) |=> state_reg == S_OUT)
        else $error("memory read state did not hand over to output");
    a_pop_source: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |-> $past(cstk_re) || $past(lstk_re))
        else $error("slot reuse without a free stack read");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for dual_pool_node_id_allocator_core
// A local model of both pools predicts every result from the accepted request
// stream. Directed requests hit the boundary cases, the leaf pool is run dry,
// and then a long random mix runs.
// Both stream sides get random gaps, and one long hold on the result side
// lets the request side back up.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned CELLS          = dpa_pkg::CELL_POOL_SIZE_DEF;
    localparam int unsigned LEAVES         = dpa_pkg::LEAF_POOL_SIZE_DEF;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          RANDOM_ITEMS   = 620;
    localparam int          MAX_REPORTS    = 10;

    // request codes that the block treats as no operation
    localparam logic [dpa_pkg::FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [dpa_pkg::FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

    logic                         clk;
    logic                         rst_n    = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [dpa_pkg::IN_W-1:0]     s_tdata  = '0;  // node_ref[31:0], node_depth[35:32], zero pad
    logic [dpa_pkg::FUNC_W-1:0]   s_tuser  = '0;  // func[2:0]
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [dpa_pkg::OUT_W-1:0]    m_tdata;        // alloc_ref[31:0], status[33:32], found[34],
                                                  // is_leaf_node[35], found_depth[39:36]

    // pending results, oldest first
    dpa_pkg::res_t                pending_results[$];
    int                           mismatch_cnt = 0;

    // ids handed out and recently released, used to build meaningful requests
    logic [dpa_pkg::REF_W-1:0]    live_ids[$];
    logic [dpa_pkg::REF_W-1:0]    freed_ids[$];

    // idle controls shared with the stream processes
    bit                           req_gaps_on = 1'b1;
    bit                           rsp_gaps_on = 1'b1;
    int                           rsp_hold    = 0;

    // local copy of the pool state
    int unsigned                  cell_count = 0;
    int unsigned                  leaf_count = 0;
    int unsigned                  cell_sp    = 0;
    int unsigned                  leaf_sp    = 0;
    logic [dpa_pkg::SLOT_W-1:0]   cell_recycle [CELLS];
    logic [dpa_pkg::SLOT_W-1:0]   leaf_recycle [LEAVES];
    logic [dpa_pkg::DEPTH_W-1:0]  cell_level  [CELLS];
    logic [dpa_pkg::DEPTH_W-1:0]  leaf_level  [LEAVES];

    dual_pool_node_id_allocator_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 60)
            return 0;
        else if (roll < 85)
            return $urandom_range(3, 1);
        else if (roll < 97)
            return $urandom_range(12, 4);
        else
            return $urandom_range(50, 20);
    endfunction

    // predict the result of one request and advance the pool state
    function automatic dpa_pkg::res_t predict_node_op(
        input logic [dpa_pkg::FUNC_W-1:0]  f,
        input logic [dpa_pkg::REF_W-1:0]   r,
        input logic [dpa_pkg::DEPTH_W-1:0] d);
        dpa_pkg::res_t             o;
        logic [dpa_pkg::REF_W-1:0] slot;
        bit                        leaf;
        o           = '0;
        o.alloc_ref = dpa_pkg::BAD_REF;
        o.status    = dpa_pkg::STAT_OK;
        slot        = r & ~dpa_pkg::LEAF_BIT;
        leaf        = r[dpa_pkg::REF_W-1];
        case (f)
            dpa_pkg::FUNC_ALLOC_CELL, dpa_pkg::FUNC_ALLOC_LEAF:
            begin
                if (d > dpa_pkg::DEPTH_LIMIT_DEF)
                    o.status = dpa_pkg::STAT_DEPTH_BAD;
                else if (f == dpa_pkg::FUNC_ALLOC_CELL)
                begin
                    // freed slot first, then a fresh one
                    if (cell_sp > 0)
                    begin
                        cell_sp--;
                        slot = dpa_pkg::REF_W'(cell_recycle[cell_sp]);
                    end
                    else if (cell_count < CELLS)
                    begin
                        slot = dpa_pkg::REF_W'(cell_count);
                        cell_count++;
                    end
                    else
                        o.status = dpa_pkg::STAT_FULL;
                    if (o.status == dpa_pkg::STAT_OK)
                    begin
                        cell_level[slot] = d;
                        o.alloc_ref      = slot;
                    end
                end
                else
                begin
                    if (leaf_sp > 0)
                    begin
                        leaf_sp--;
                        slot = dpa_pkg::REF_W'(leaf_recycle[leaf_sp]);
                    end
                    else if (leaf_count < LEAVES)
                    begin
                        slot = dpa_pkg::REF_W'(leaf_count);
                        leaf_count++;
                    end
                    else
                        o.status = dpa_pkg::STAT_FULL;
                    if (o.status == dpa_pkg::STAT_OK)
                    begin
                        leaf_level[slot] = d;
                        o.alloc_ref      = slot | dpa_pkg::LEAF_BIT;
                        o.is_leaf_node   = 1'b1;
                    end
                end
            end
            dpa_pkg::FUNC_FREE:
            begin
                // the invalid id is silently ignored
                if (r != dpa_pkg::BAD_REF)
                begin
                    if (!leaf)
                    begin
                        if (slot >= cell_count)
                            o.status = dpa_pkg::STAT_RANGE;
                        else if (cell_sp >= CELLS)
                            o.status = dpa_pkg::STAT_FULL;
                        else
                        begin
                            cell_recycle[cell_sp] = slot[dpa_pkg::SLOT_W-1:0];
                            cell_sp++;
                        end
                    end
                    else
                    begin
                        if (slot >= leaf_count)
                            o.status = dpa_pkg::STAT_RANGE;
                        else if (leaf_sp >= LEAVES)
                            o.status = dpa_pkg::STAT_FULL;
                        else
                        begin
                            leaf_recycle[leaf_sp] = slot[dpa_pkg::SLOT_W-1:0];
                            leaf_sp++;
                        end
                    end
                end
            end
            dpa_pkg::FUNC_CLEAR:
            begin
                cell_count = 0;
                leaf_count = 0;
                cell_sp    = 0;
                leaf_sp    = 0;
            end
            dpa_pkg::FUNC_LOOKUP:
            begin
                if (r != dpa_pkg::BAD_REF)
                begin
                    if (slot >= (leaf ? leaf_count : cell_count))
                        o.status = dpa_pkg::STAT_RANGE;
                    else
                    begin
                        o.found        = 1'b1;
                        o.is_leaf_node = leaf;
                        o.found_depth  = leaf ? leaf_level[slot] : cell_level[slot];
                    end
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    // offer one request, wait for the transaction, record its expected result
    task automatic send_req(input logic [dpa_pkg::FUNC_W-1:0]  f,
                            input logic [dpa_pkg::REF_W-1:0]   r,
                            input logic [dpa_pkg::DEPTH_W-1:0] d);
        int            gap;
        dpa_pkg::res_t pred;
        gap = req_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {{(dpa_pkg::IN_W - dpa_pkg::REF_W - dpa_pkg::DEPTH_W){1'b0}}, d, r};
        do @(posedge clk); while (!s_tready);
        pred = predict_node_op(f, r, d);
        pending_results.push_back(pred);
        // bookkeeping for later requests
        if ((f == dpa_pkg::FUNC_ALLOC_CELL || f == dpa_pkg::FUNC_ALLOC_LEAF)
            && pred.status == dpa_pkg::STAT_OK)
            live_ids.push_back(pred.alloc_ref);
        else if (f == dpa_pkg::FUNC_FREE && pred.status == dpa_pkg::STAT_OK
                 && r != dpa_pkg::BAD_REF)
        begin
            freed_ids.push_back(r);
            if (freed_ids.size() > 32)
                void'(freed_ids.pop_front());
        end
        else if (f == dpa_pkg::FUNC_CLEAR)
        begin
            live_ids.delete();
            freed_ids.delete();
        end
    endtask

    // hold the request side until every result is back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // one request of the random mix: mostly sensible ids, some noise
    task automatic send_random_item();
        int                          sel;
        int                          k;
        logic [dpa_pkg::FUNC_W-1:0]  f;
        logic [dpa_pkg::REF_W-1:0]   r;
        logic [dpa_pkg::DEPTH_W-1:0] d;
        sel = $urandom_range(99, 0);
        if ($urandom_range(9, 0) == 0)
            d = dpa_pkg::DEPTH_W'($urandom_range(4'hF, dpa_pkg::DEPTH_LIMIT_DEF + 1));
        else
            d = dpa_pkg::DEPTH_W'($urandom_range(dpa_pkg::DEPTH_LIMIT_DEF, 0));
        case ($urandom_range(3, 0))
            0:       r = $urandom;
            1:       r = dpa_pkg::BAD_REF;
            2:       r = $urandom_range(2047, 0);
            default: r = dpa_pkg::LEAF_BIT | $urandom_range(2047, 0);
        endcase
        if (sel < 30)
            f = dpa_pkg::FUNC_ALLOC_CELL;
        else if (sel < 55)
            f = dpa_pkg::FUNC_ALLOC_LEAF;
        else if (sel < 75)
        begin
            f = dpa_pkg::FUNC_FREE;
            if (live_ids.size() > 0 && $urandom_range(9, 0) < 8)
            begin
                k = $urandom_range(live_ids.size() - 1, 0);
                r = live_ids[k];
                live_ids.delete(k);
            end
            else if (freed_ids.size() > 0 && $urandom_range(1, 0) == 0)
                r = freed_ids[$urandom_range(freed_ids.size() - 1, 0)];
        end
        else if (sel < 94)
        begin
            f = dpa_pkg::FUNC_LOOKUP;
            k = $urandom_range(9, 0);
            if (live_ids.size() > 0 && k < 6)
                r = live_ids[$urandom_range(live_ids.size() - 1, 0)];
            else if (freed_ids.size() > 0 && k < 8)
                r = freed_ids[$urandom_range(freed_ids.size() - 1, 0)];
        end
        else if (sel < 96)
            f = dpa_pkg::FUNC_CLEAR;
        else
            f = dpa_pkg::FUNC_W'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
        send_req(f, r, d);
    endtask

    // boundary cases of every request kind
    task automatic test_directed();
        send_req(dpa_pkg::FUNC_LOOKUP, '0, '0);              // lookup in an empty pool
        send_req(dpa_pkg::FUNC_LOOKUP, dpa_pkg::BAD_REF, 4'hF); // lookup of the invalid id
        send_req(dpa_pkg::FUNC_FREE, dpa_pkg::BAD_REF, '0);  // free of the invalid id
        send_req(dpa_pkg::FUNC_FREE, '0, '0);                // free beyond used range
        send_req(dpa_pkg::FUNC_ALLOC_CELL, '0, '0);
        // depth right at the limit, then just above it
        send_req(dpa_pkg::FUNC_ALLOC_CELL, '0, dpa_pkg::DEPTH_W'(dpa_pkg::DEPTH_LIMIT_DEF));
        send_req(dpa_pkg::FUNC_ALLOC_CELL, '0,
                 dpa_pkg::DEPTH_W'(dpa_pkg::DEPTH_LIMIT_DEF + 1));
        send_req(dpa_pkg::FUNC_ALLOC_LEAF, dpa_pkg::BAD_REF, 4'hF);
        send_req(dpa_pkg::FUNC_ALLOC_LEAF, '0, dpa_pkg::DEPTH_W'(dpa_pkg::DEPTH_LIMIT_DEF));
        send_req(dpa_pkg::FUNC_ALLOC_LEAF, '0, 4'd5);
        send_req(dpa_pkg::FUNC_LOOKUP, 32'd1, '0);
        send_req(dpa_pkg::FUNC_LOOKUP, dpa_pkg::LEAF_BIT, '0);
        send_req(dpa_pkg::FUNC_LOOKUP, ~dpa_pkg::LEAF_BIT, '0); // largest cell id
        send_req(dpa_pkg::FUNC_LOOKUP, 32'hFFFF_FFFE, '0);   // largest valid leaf id
        send_req(dpa_pkg::FUNC_FREE, '0, '0);
        send_req(dpa_pkg::FUNC_LOOKUP, '0, '0);              // freed node still visible
        send_req(dpa_pkg::FUNC_ALLOC_CELL, '0, 4'd3);        // takes the freed slot back
        send_req(dpa_pkg::FUNC_FREE, dpa_pkg::LEAF_BIT | 32'd1, '0);
        send_req(dpa_pkg::FUNC_FREE, 32'hFFFF_FFFE, '0);
        send_req(dpa_pkg::FUNC_ALLOC_LEAF, '0, 4'd7);
        send_req(FUNC_UNUSED_LO, $urandom, 4'hF);
        send_req(FUNC_UNUSED_LO + 3'd1, $urandom, '0);
        send_req(FUNC_UNUSED_HI, $urandom, 4'hA);
        send_req(dpa_pkg::FUNC_CLEAR, '0, '0);
        send_req(dpa_pkg::FUNC_LOOKUP, '0, '0);              // gone after clear
        send_req(dpa_pkg::FUNC_ALLOC_CELL, '0, 4'd1);
    endtask

    // run the leaf pool dry, then recycle from it
    task automatic test_leaf_exhaustion();
        send_req(dpa_pkg::FUNC_CLEAR, '0, '0);
        repeat (LEAVES + 2)
            send_req(dpa_pkg::FUNC_ALLOC_LEAF, $urandom,
                     dpa_pkg::DEPTH_W'($urandom_range(dpa_pkg::DEPTH_LIMIT_DEF, 0)));
        send_req(dpa_pkg::FUNC_LOOKUP, dpa_pkg::LEAF_BIT | (LEAVES - 1), '0);
        send_req(dpa_pkg::FUNC_LOOKUP, dpa_pkg::LEAF_BIT | LEAVES, '0);
        send_req(dpa_pkg::FUNC_FREE, dpa_pkg::LEAF_BIT | (LEAVES - 1), '0);
        send_req(dpa_pkg::FUNC_ALLOC_LEAF, '0, 4'd9);
        send_req(dpa_pkg::FUNC_ALLOC_LEAF, '0, 4'd9);
    endtask

    // long hold on the result side while requests keep coming
    task automatic test_backpressure();
        req_gaps_on = 1'b0;
        rsp_hold    = 300;
        repeat (24)
            send_random_item();
        wait_drain();
        req_gaps_on = 1'b1;
    endtask

    // long random mix with changing idle patterns
    task automatic test_random_mix();
        send_req(dpa_pkg::FUNC_CLEAR, '0, '0);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
            begin
                req_gaps_on = ($urandom_range(3, 0) != 0);
                rsp_gaps_on = ($urandom_range(3, 0) != 0);
            end
            send_random_item();
        end
        req_gaps_on = 1'b1;
        rsp_gaps_on = 1'b1;
    endtask

    // result side ready: random gaps, or a long hold when asked
    initial
    begin
        int idle_left;
        idle_left = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold > 0)
            begin
                m_tready <= 1'b0;
                rsp_hold--;
            end
            else if (idle_left > 0)
            begin
                m_tready <= 1'b0;
                idle_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (rsp_gaps_on)
                    idle_left = pick_gap();
            end
        end
    end

    // record one field mismatch
    task automatic note_mismatch(input string name, input logic [dpa_pkg::REF_W-1:0] want,
                                 input logic [dpa_pkg::REF_W-1:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: %s differs, expected %h, got %h", $realtime, name, want, got);
    endtask

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : result_check
        dpa_pkg::res_t want;
        dpa_pkg::res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = dpa_pkg::res_t'(m_tdata);
            if (pending_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("%0t: result %h with no request pending", $realtime, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.alloc_ref !== want.alloc_ref)
                    note_mismatch("alloc_ref", want.alloc_ref, got.alloc_ref);
                if (got.status !== want.status)
                    note_mismatch("status", dpa_pkg::REF_W'(want.status),
                                  dpa_pkg::REF_W'(got.status));
                if (got.found !== want.found)
                    note_mismatch("found", dpa_pkg::REF_W'(want.found),
                                  dpa_pkg::REF_W'(got.found));
                if (got.is_leaf_node !== want.is_leaf_node)
                    note_mismatch("is_leaf_node", dpa_pkg::REF_W'(want.is_leaf_node),
                                  dpa_pkg::REF_W'(got.is_leaf_node));
                if (got.found_depth !== want.found_depth)
                    note_mismatch("found_depth", dpa_pkg::REF_W'(want.found_depth),
                                  dpa_pkg::REF_W'(got.found_depth));
            end
        end
    end

    // watchdog: too long without any transaction
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: watchdog, no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // test sequence
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drain();
        test_leaf_exhaustion();
        wait_drain();
        test_backpressure();
        test_random_mix();
        wait_drain();
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/dpa_pkg.sv
hw/rtl/dpa_front.sv
hw/rtl/dpa_queue.sv
hw/rtl/dpa_back.sv
hw/rtl/dual_pool_node_id_allocator_core.sv
tb/testbench.sv
